@@ rtl/lld_pkg.sv @@
// ----------------------------------------------------------------------------
// lld_pkg
// Shared types and constants for the addressable LED line driver: command and
// result payloads, queue entries, configuration snapshot and register indexes.
// ----------------------------------------------------------------------------
package lld_pkg;

  // widths fixed by the field and register definitions
  localparam int COUNT_W    = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COLOR_W    = 24;
  localparam int BIT_POS_W  = 5;
  localparam int TICK_W     = 16;

  // default chain capacity and the largest store the 8-bit index can reach
  localparam int DEF_MAX_LEDS = 256;
  localparam int STORE_LIMIT  = 256;
  localparam int BITS_PER_LED = 24;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LED_COUNT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE_HIGH   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE_LOW    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_HIGH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LOW   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_LATCH_LOW  = 3'd5;

  // configuration reset values
  localparam logic [COUNT_W-1:0] RST_LED_COUNT = 9'd0;
  localparam logic [7:0]         RST_ONE_HIGH  = 8'd6;
  localparam logic [7:0]         RST_ONE_LOW   = 8'd4;
  localparam logic [7:0]         RST_ZERO_HIGH = 8'd2;
  localparam logic [7:0]         RST_ZERO_LOW  = 8'd8;
  localparam logic [TICK_W-1:0]  RST_LATCH_LOW = 16'd1000;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_WRITE,
    OP_BAD_WRITE,
    OP_REFRESH,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] led_index;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } result_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         index;
    logic [COLOR_W-1:0] color;
  } entry_t;

  // configuration snapshot, with the count already limited to the chain size
  typedef struct packed {
    logic [COUNT_W-1:0] eff_count;
    logic [7:0]         one_high;
    logic [7:0]         one_low;
    logic [7:0]         zero_high;
    logic [7:0]         zero_low;
    logic [TICK_W-1:0]  latch_low;
  } cfg_t;

endpackage

@@ rtl/addressable_led_line_driver.sv @@
// ----------------------------------------------------------------------------
// addressable_led_line_driver
// Serial line driver for a chain of addressable RGB LEDs with a color store.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd_data) carries tick, color write,
//   refresh and clear commands; each accepted command gives exactly one
//   result on the res channel (res_valid/res_stall/res_data) with the line
//   level after the command, the busy flag and the reject flag.
//   A tick is one clock of line timing; other commands do not advance time.
//   Throughput: one command per clock, sustained, while the receiver takes
//   results. A command passes the input stage, the two-entry queue and the
//   executing stage with result register. The next LED's color is prefetched
//   from the store while the current LED is sent, so the store's single read
//   port never limits rate. When the receiver stalls, the result register
//   holds and the queue fills; cmd_stall then rises. Configuration writes
//   (cfg_write/cfg_index/cfg_data) take effect at once and must be issued by
//   the user only while the block is idle; the block does not enforce it.
//   Reset clears the color store (valid bits), the sequencer and all
//   configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module addressable_led_line_driver
  import lld_pkg::*;
#(
  parameter int MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  item_t                 cmd_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output result_t               res_data
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;
  cfg_t   cfg;

  // command intake and classification
  lld_front #(
    .MAX_LEDS(MAX_LEDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .push      (push),
    .push_entry(push_entry),
    .q_full    (q_full),
    .cfg       (cfg)
  );

  // queue between intake and execution
  lld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .head_valid(head_valid),
    .pop       (pop),
    .head_entry(head_entry)
  );

  // store, frame sequencer and result register
  lld_back #(
    .MAX_LEDS(MAX_LEDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

@@ rtl/lld_queue.sv @@
// ----------------------------------------------------------------------------
// lld_queue
// Two-entry queue of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module lld_queue
  import lld_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output logic   head_valid,
  input  logic   pop,
  output entry_t head_entry
);

  localparam int DEPTH = 2;

  entry_t           slots [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full       = (count == 2'(DEPTH));
  assign head_valid = (count != 2'd0);
  assign head_entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/lld_front.sv @@
// ----------------------------------------------------------------------------
// lld_front
// Holds the configuration registers, takes command transfers, classifies
// each command (range check of color writes) and hands it to the queue.
// ----------------------------------------------------------------------------
module lld_front
  import lld_pkg::*;
#(
  parameter int MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  item_t                 cmd_data,
  output logic                  push,
  output entry_t                push_entry,
  input  logic                  q_full,
  output cfg_t                  cfg
);

  // largest count the 9-bit register can express, limited by the chain size
  localparam int                 CAP   = (MAX_LEDS > 511) ? 511 : MAX_LEDS;
  localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);

  logic [COUNT_W-1:0] led_count;
  logic [7:0]         one_high;
  logic [7:0]         one_low;
  logic [7:0]         zero_high;
  logic [7:0]         zero_low;
  logic [TICK_W-1:0]  latch_low;

  logic   stage_valid;
  entry_t stage_entry;
  entry_t classified;
  logic   accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= RST_LED_COUNT;
      one_high  <= RST_ONE_HIGH;
      one_low   <= RST_ONE_LOW;
      zero_high <= RST_ZERO_HIGH;
      zero_low  <= RST_ZERO_LOW;
      latch_low <= RST_LATCH_LOW;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LED_COUNT: led_count <= cfg_data[COUNT_W-1:0];
        CFG_ONE_HIGH:  one_high  <= cfg_data[7:0];
        CFG_ONE_LOW:   one_low   <= cfg_data[7:0];
        CFG_ZERO_HIGH: zero_high <= cfg_data[7:0];
        CFG_ZERO_LOW:  zero_low  <= cfg_data[7:0];
        CFG_LATCH_LOW: latch_low <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration snapshot for the back
  always_comb begin
    cfg.eff_count = (led_count < CAP_V) ? led_count : CAP_V;
    cfg.one_high  = one_high;
    cfg.one_low   = one_low;
    cfg.zero_high = zero_high;
    cfg.zero_low  = zero_low;
    cfg.latch_low = latch_low;
  end

  // classify the incoming command
  always_comb begin
    classified.index = cmd_data.led_index;
    classified.color = {cmd_data.green, cmd_data.red, cmd_data.blue};
    case (cmd_data.cmd)
      CMD_TICK:    classified.op = OP_TICK;
      CMD_WRITE:   classified.op = ({1'b0, cmd_data.led_index} < cfg.eff_count) ?
                                   OP_WRITE : OP_BAD_WRITE;
      CMD_REFRESH: classified.op = OP_REFRESH;
      CMD_CLEAR:   classified.op = OP_CLEAR;
      default:     classified.op = OP_TICK;
    endcase
  end

  // input stage handshake
  assign cmd_stall  = stage_valid && q_full;
  assign accept     = cmd_valid && !cmd_stall;
  assign push       = stage_valid && !q_full;
  assign push_entry = stage_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_entry <= classified;
    end
  end

endmodule

@@ rtl/lld_back.sv @@
// ----------------------------------------------------------------------------
// lld_back
// Executes queued operations: color store, frame sequencer driving the line
// level, and the result register toward the receiver.
// ----------------------------------------------------------------------------
module lld_back
  import lld_pkg::*;
#(
  parameter int MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    head_valid,
  input  entry_t  head_entry,
  output logic    pop,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res_data
);

  localparam int STORE_DEPTH = (MAX_LEDS < STORE_LIMIT) ? MAX_LEDS : STORE_LIMIT;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SLOTS       = 2 ** AW;
  localparam logic [COUNT_W:0]   DEPTH_V  = (COUNT_W + 1)'(STORE_DEPTH);
  localparam logic [BIT_POS_W-1:0] LAST_BIT = BIT_POS_W'(BITS_PER_LED - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LATCH,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // color store with per-entry valid bits (invalid entries read as zero)
  logic [COLOR_W-1:0] store [SLOTS];
  logic [SLOTS-1:0]   store_ok;

  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  led_position, led_position_next;
  logic [BIT_POS_W-1:0] bit_position, bit_position_next;
  logic [TICK_W-1:0]   phase_counter, phase_counter_next;
  logic                line_reg, line_reg_next;
  logic [COLOR_W-1:0]  cur_color, cur_color_next;
  logic                rejected;
  logic                wr_en;
  logic                clr_en;

  // prefetch of the next LED color
  logic [COUNT_W:0]    fetch_pos;
  logic                fetch_in_range;
  logic [AW-1:0]       rd_addr_q;
  logic                rd_in_range_q;
  logic [COLOR_W-1:0]  rd_data_q;
  logic [COLOR_W-1:0]  fetched;

  logic [BIT_POS_W-1:0] bit_sel;
  logic [BIT_POS_W-1:0] next_sel;
  logic                 cur_bit;
  logic                 first_bit;
  logic                 next_bit;
  logic [TICK_W-1:0]    cnt_dec;
  logic [COUNT_W-1:0]   led_inc;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? TICK_W'(1) : TICK_W'(v);
  endfunction

  assign pop = head_valid && (!res_valid || !res_stall);

  // fetch address: LED 0 before a frame's bits, else the LED after the current
  always_comb begin
    if (phase == PH_IDLE || phase == PH_LATCH) begin
      fetch_pos = '0;
    end else begin
      fetch_pos = {1'b0, led_position} + (COUNT_W + 1)'(1);
    end
    fetch_in_range = (fetch_pos < DEPTH_V);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[head_entry.index[AW-1:0]] <= head_entry.color;
    end
    rd_data_q     <= store[fetch_pos[AW-1:0]];
    rd_addr_q     <= fetch_pos[AW-1:0];
    rd_in_range_q <= fetch_in_range;
  end

  assign fetched = (rd_in_range_q && store_ok[rd_addr_q]) ? rd_data_q : '0;

  // valid bits: set on write, cleared below the count on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      store_ok <= '0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (clr_en && ((COUNT_W + 1)'(i) < {1'b0, cfg.eff_count})) begin
          store_ok[i] <= 1'b0;
        end
      end
      if (wr_en) begin
        store_ok[head_entry.index[AW-1:0]] <= 1'b1;
      end
    end
  end

  // bit selection within the current and the next color
  assign bit_sel   = LAST_BIT - bit_position;
  assign next_sel  = bit_sel - BIT_POS_W'(1);
  assign cur_bit   = cur_color[bit_sel];
  assign first_bit = fetched[COLOR_W-1];
  assign cnt_dec   = phase_counter - TICK_W'(1);
  assign led_inc   = led_position + COUNT_W'(1);

  // next-state logic of the frame sequencer
  always_comb begin
    phase_next         = phase;
    led_position_next  = led_position;
    bit_position_next  = bit_position;
    phase_counter_next = phase_counter;
    line_reg_next      = line_reg;
    cur_color_next     = cur_color;
    rejected           = 1'b0;
    wr_en              = 1'b0;
    clr_en             = 1'b0;
    next_bit           = 1'b0;

    if (pop) begin
      case (head_entry.op)
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            phase_counter_next = cnt_dec;
            if (cnt_dec == '0) begin
              case (phase)
                PH_LATCH: begin
                  led_position_next = '0;
                  bit_position_next = '0;
                  if (cfg.eff_count == '0) begin
                    phase_next    = PH_IDLE;
                    line_reg_next = 1'b0;
                  end else begin
                    cur_color_next     = fetched;
                    phase_next         = PH_HIGH;
                    line_reg_next      = 1'b1;
                    phase_counter_next = at_least_one(first_bit ? cfg.one_high :
                                                                  cfg.zero_high);
                  end
                end
                PH_HIGH: begin
                  phase_next         = PH_LOW;
                  line_reg_next      = 1'b0;
                  phase_counter_next = at_least_one(cur_bit ? cfg.one_low :
                                                              cfg.zero_low);
                end
                PH_LOW: begin
                  if (bit_position == LAST_BIT) begin
                    bit_position_next = '0;
                    led_position_next = led_inc;
                    cur_color_next    = fetched;
                    next_bit          = first_bit;
                  end else begin
                    bit_position_next = bit_position + BIT_POS_W'(1);
                    next_bit          = cur_color[next_sel];
                  end
                  if (led_position_next >= cfg.eff_count) begin
                    phase_next         = PH_IDLE;
                    line_reg_next      = 1'b0;
                    phase_counter_next = '0;
                    led_position_next  = '0;
                    bit_position_next  = '0;
                  end else begin
                    phase_next         = PH_HIGH;
                    line_reg_next      = 1'b1;
                    phase_counter_next = at_least_one(next_bit ? cfg.one_high :
                                                                 cfg.zero_high);
                  end
                end
                default: ;
              endcase
            end
          end
        end
        OP_WRITE, OP_BAD_WRITE, OP_REFRESH, OP_CLEAR: begin
          if (phase != PH_IDLE) begin
            rejected = 1'b1;
          end else if (head_entry.op == OP_WRITE) begin
            wr_en = 1'b1;
          end else if (head_entry.op == OP_BAD_WRITE) begin
            rejected = 1'b1;
          end else begin
            clr_en             = (head_entry.op == OP_CLEAR);
            phase_next         = PH_LATCH;
            line_reg_next      = 1'b0;
            phase_counter_next = (cfg.latch_low == '0) ? TICK_W'(1) : cfg.latch_low;
            led_position_next  = '0;
            bit_position_next  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      led_position  <= '0;
      bit_position  <= '0;
      phase_counter <= '0;
      line_reg      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      led_position  <= led_position_next;
      bit_position  <= bit_position_next;
      phase_counter <= phase_counter_next;
      line_reg      <= line_reg_next;
      if (pop) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_color <= cur_color_next;
    if (pop) begin
      res_data.line_level <= line_reg_next;
      res_data.busy_res   <= (phase_next != PH_IDLE);
      res_data.rejected   <= rejected;
    end
  end

endmodule

@@ tb/addressable_led_line_driver_tb.sv @@
// ----------------------------------------------------------------------------
// addressable_led_line_driver_tb
// Self-checking bench for the LED line driver. Command transfers are fed from
// a backlog by a clocked driver; each accepted command is run through a local
// line model that yields the expected line level, busy and reject flags. A
// clocked monitor checks every result transfer against that model, in order.
// Directed steps cover an empty chain, zero widths, the index limits of the
// largest chain, clears, rejects while busy, a long receiver hold-off and a
// mid-frame register change; short random frames follow.
// ----------------------------------------------------------------------------
module addressable_led_line_driver_tb;
  import lld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAIN_MAX = DEF_MAX_LEDS;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 550;

  // sequencer phases of the local line model
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LATCH,
    SEQ_HIGH,
    SEQ_LOW
  } seq_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  item_t                 cmd_data = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  result_t               res_data;

  addressable_led_line_driver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line model: color store, sequencer and register copies
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] shadow_colors [CHAIN_MAX];
  int unsigned        m_led;
  int unsigned        m_bit;
  int unsigned        m_left;
  seq_t               m_seq;
  logic               m_line;

  logic [COUNT_W-1:0] r_count;
  logic [7:0]         r_one_high;
  logic [7:0]         r_one_low;
  logic [7:0]         r_zero_high;
  logic [7:0]         r_zero_low;
  logic [TICK_W-1:0]  r_latch;

  function automatic int unsigned min1(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned live_leds();
    return (r_count < CHAIN_MAX) ? r_count : CHAIN_MAX;
  endfunction

  // bit under the sequencer, green msb first
  function automatic logic bit_now();
    logic [COLOR_W-1:0] color;
    color = '0;
    if (m_led < CHAIN_MAX) color = shadow_colors[m_led];
    return color[COLOR_W-1-(m_bit % BITS_PER_LED)];
  endfunction

  function automatic void open_bit();
    m_seq = SEQ_HIGH;
    m_line = 1'b1;
    m_left = min1(bit_now() ? r_one_high : r_zero_high);
  endfunction

  // one clock of line timing
  function automatic void advance_line();
    if (m_seq == SEQ_IDLE) return;
    if (m_left > 0) m_left--;
    if (m_left != 0) return;
    case (m_seq)
      SEQ_LATCH: begin
        m_led = 0;
        m_bit = 0;
        if (live_leds() == 0) begin
          m_seq = SEQ_IDLE;
          m_line = 1'b0;
        end else begin
          open_bit();
        end
      end
      SEQ_HIGH: begin
        m_seq = SEQ_LOW;
        m_line = 1'b0;
        m_left = min1(bit_now() ? r_one_low : r_zero_low);
      end
      default: begin
        m_bit++;
        if (m_bit >= BITS_PER_LED) begin
          m_bit = 0;
          m_led++;
        end
        if (m_led >= live_leds()) begin
          m_seq = SEQ_IDLE;
          m_line = 1'b0;
          m_left = 0;
          m_led = 0;
          m_bit = 0;
        end else begin
          open_bit();
        end
      end
    endcase
  endfunction

  // expected line result for one accepted command
  function automatic result_t predict_line(item_t it);
    result_t res;
    logic    busy;
    res = '0;
    busy = (m_seq != SEQ_IDLE);
    if (it.cmd == CMD_TICK) begin
      advance_line();
    end else if (busy) begin
      res.rejected = 1'b1;
    end else if (it.cmd == CMD_WRITE) begin
      if (it.led_index >= live_leds()) res.rejected = 1'b1;
      else shadow_colors[it.led_index] = {it.green, it.red, it.blue};
    end else begin
      if (it.cmd == CMD_CLEAR)
        for (int i = 0; i < live_leds(); i++) shadow_colors[i] = '0;
      m_seq = SEQ_LATCH;
      m_line = 1'b0;
      m_left = min1(r_latch);
      m_led = 0;
      m_bit = 0;
    end
    res.line_level = m_line;
    res.busy_res = (m_seq != SEQ_IDLE);
    return res;
  endfunction

  initial begin
    foreach (shadow_colors[i]) shadow_colors[i] = '0;
    m_led = 0;
    m_bit = 0;
    m_left = 0;
    m_seq = SEQ_IDLE;
    m_line = 1'b0;
    r_count = RST_LED_COUNT;
    r_one_high = RST_ONE_HIGH;
    r_one_low = RST_ONE_LOW;
    r_zero_high = RST_ZERO_HIGH;
    r_zero_low = RST_ZERO_LOW;
    r_latch = RST_LATCH_LOW;
  end

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  item_t       cmd_backlog [$];
  result_t     line_expect [$];
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cmds_issued = 0;
  int unsigned ticks_issued = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned phase_count = 0;

  // command driver
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (cmd_valid && !cmd_stall) line_expect.push_back(predict_line(cmd_data));
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(0, 7);
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cmd_valid <= 1'b1;
          cmd_data <= cmd_backlog.pop_front();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  task automatic check_bit(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (line_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %b", $realtime, res_data);
          fail_count++;
        end else begin
          want = line_expect.pop_front();
          check_bit("line_level", want.line_level, res_data.line_level);
          check_bit("busy_res", want.busy_res, res_data.busy_res);
          check_bit("rejected", want.rejected, res_data.rejected);
        end
        results_checked++;
      end
      // one long hold-off so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 79;
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(cmd_t op, logic [7:0] idx, logic [7:0] g, logic [7:0] rd,
                           logic [7:0] bl);
    item_t it;
    it.cmd = op;
    it.led_index = idx;
    it.green = g;
    it.red = rd;
    it.blue = bl;
    cmd_backlog.push_back(it);
    if (op == CMD_TICK) ticks_issued++;
    else cmds_issued++;
  endtask

  task automatic push_random(cmd_t op);
    push_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LED_COUNT: r_count = val[COUNT_W-1:0];
      CFG_ONE_HIGH:  r_one_high = val[7:0];
      CFG_ONE_LOW:   r_one_low = val[7:0];
      CFG_ZERO_HIGH: r_zero_high = val[7:0];
      CFG_ZERO_LOW:  r_zero_low = val[7:0];
      default:       r_latch = val;
    endcase
  endtask

  // wait until every queued command has its result back
  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_valid || line_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // registers are only written with no command in flight
  task automatic configure(int unsigned cnt, int unsigned oh, int unsigned ol,
                           int unsigned zh, int unsigned zl, int unsigned lat);
    drain();
    write_reg(CFG_LED_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_ONE_HIGH, CFG_DATA_W'(oh));
    write_reg(CFG_ONE_LOW, CFG_DATA_W'(ol));
    write_reg(CFG_ZERO_HIGH, CFG_DATA_W'(zh));
    write_reg(CFG_ZERO_LOW, CFG_DATA_W'(zl));
    write_reg(CFG_LATCH_LOW, CFG_DATA_W'(lat));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // tick until the model says the frame is over
  task automatic run_to_idle();
    drain();
    while (m_seq != SEQ_IDLE) begin
      repeat (8) push_random(CMD_TICK);
      drain();
    end
  endtask

  // ticks that cover a whole frame at the current settings
  function automatic int unsigned frame_span();
    int unsigned hi;
    int unsigned lo;
    hi = (min1(r_one_high) > min1(r_zero_high)) ? min1(r_one_high) : min1(r_zero_high);
    lo = (min1(r_one_low) > min1(r_zero_low)) ? min1(r_one_low) : min1(r_zero_low);
    return min1(r_latch) + BITS_PER_LED * live_leds() * (hi + lo) + 2;
  endfunction

  function automatic int unsigned pick_width();
    if ($urandom_range(0, 7) == 0) return $urandom_range(3, 6);
    return $urandom_range(0, 2);
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned cnt;
    int unsigned live;
    int unsigned span;
    int unsigned lat;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // register defaults: empty chain rejects writes, idle ticks change nothing
    push_random(CMD_TICK);
    push_item(CMD_WRITE, 8'd0, 8'h12, 8'h34, 8'h56);
    push_random(CMD_TICK);
    drain();

    // empty chain with zero widths: refresh is latch only
    configure(0, 0, 0, 0, 0, 2);
    push_item(CMD_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0);
    run_to_idle();

    // index limits of the largest chain, no frame sent
    configure(511, 1, 1, 1, 1, 1);
    push_item(CMD_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_WRITE, 8'd0, 8'hA5, 8'h5A, 8'h00);
    configure(256, 1, 1, 1, 1, 1);
    push_item(CMD_WRITE, 8'd128, 8'h00, 8'hFF, 8'h00);
    configure(255, 1, 1, 1, 1, 1);
    push_item(CMD_WRITE, 8'd255, 8'h80, 8'h01, 8'h7F);
    push_item(CMD_WRITE, 8'd254, 8'h01, 8'h80, 8'hFE);

    // zero widths on one LED, commands while busy, long receiver hold-off
    configure(1, 0, 0, 0, 0, 0);
    push_item(CMD_WRITE, 8'd0, 8'hA5, 8'h5A, 8'h3C);
    push_item(CMD_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (20) push_random(CMD_TICK);
    push_item(CMD_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (40) push_random(CMD_TICK);
    hold_req = 1'b1;
    run_to_idle();

    // clear zeroes the live entries, then sends them
    configure(1, 1, 1, 1, 1, 1);
    push_item(CMD_CLEAR, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    run_to_idle();

    // count and widths changed while a frame is on the line
    configure(3, 1, 2, 2, 1, 3);
    push_random(CMD_WRITE);
    push_item(CMD_WRITE, 8'd1, 8'hFF, 8'h00, 8'hAA);
    push_item(CMD_WRITE, 8'd2, 8'h55, 8'hFF, 8'h00);
    push_item(CMD_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (30) push_random(CMD_TICK);
    configure(1, 4, 2, 2, 1, 3);
    run_to_idle();

    // random phases: writes, then a refresh or clear, then its ticks
    while (cmds_issued + ticks_issued < ITEM_TARGET - 100) begin
      phase_count++;
      if (cmds_issued + ticks_issued >= ITEM_TARGET - 150) quiet = 1'b1;
      run_to_idle();
      case ($urandom_range(0, 15))
        0:       cnt = 0;
        14, 15:  cnt = 2;
        default: cnt = 1;
      endcase
      lat = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 4);
      configure(cnt, pick_width(), pick_width(), pick_width(), pick_width(), lat);
      if (frame_span() > 160) configure(cnt, 1, 1, 1, 1, lat);
      live = live_leds();
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 5) == 0 || live == 0)
            push_random(CMD_WRITE);
          else
            push_item(CMD_WRITE, 8'($urandom_range(0, live - 1)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0) push_random(cmd_t'($urandom_range(0, 3)));
        push_random(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_REFRESH);
        span = frame_span();
        if ($urandom_range(0, 5) == 0) span = $urandom_range(0, span);
        repeat (span) begin
          if ($urandom_range(0, 24) == 0) push_random(cmd_t'($urandom_range(1, 3)));
          push_random(CMD_TICK);
        end
      end
    end

    run_to_idle();
    repeat (20) @(posedge clk);
    if (line_expect.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, line_expect.size());
      fail_count++;
    end
    $display("covered %0d commands and %0d ticks over %0d random phases plus directed frames",
             cmds_issued, ticks_issued, phase_count);
    $display("%0d results checked, %0d failures", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
